@@ rtl/mrfs_pkg.sv @@
package mrfs_pkg;

    localparam int DEPTH_DEFAULT     = 16;
    localparam int WORD_BITS_DEFAULT = 64;

    // Fixed field widths of the stream payloads.
    localparam int CMD_W       = 2;
    localparam int MSG_W       = 64;
    localparam int FIELD5_W    = 5;
    localparam int S_TDATA_W   = 72;
    localparam int M_TDATA_W   = 80;

    localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

    // Keeps the low five bits of a count, as the result fields carry it.
    function automatic logic [FIELD5_W-1:0] to_field5(input logic [31:0] value);
        return value[FIELD5_W-1:0];
    endfunction

endpackage

@@ rtl/message_ring_fifo_with_search_unit.sv @@
// Ring FIFO of message words with a search by equality.
// The slave stream carries one command per transaction: s_tdata holds cmd (2 bits)
// and msg_word (64 bits). Command 0 pushes a word, 1 pops the oldest word, 2 searches
// the stored words from oldest to newest for the first equal one.
// Every command gives exactly one result transaction on the master stream: ok,
// read_word, found_position, free_slots and used_slots after the operation.
// The block works on one command at a time and s_tready is low while it is busy.
// A push, an unused code, a pop of an empty ring and a search of an empty ring go
// from the accepting edge straight to ST_OUT, which loads the result register once
// it is free. A pop of a stored word passes through ST_POP first (one registered
// read of the slot memory). A search runs in ST_SRCH, where a single comparator checks
// one word per cycle as it comes out of the one read port of the slot memory. s_tready
// rises at the same edge that loads the result register.
// A result waits in the output register while m_tready is low. The block still
// accepts one more command, holds that result until the output register is free,
// and only then raises s_tready again.
// Reset empties the ring (both indices zero, no words stored); slot contents are
// not cleared since only written slots are ever read.
module message_ring_fifo_with_search_unit
    import mrfs_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEFAULT,
    parameter int WORD_BITS = WORD_BITS_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // From bit 0: cmd[1:0], msg_word[63:0], zero padding.
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // From bit 0: ok, read_word[63:0], found_position[4:0], free_slots[4:0],
    // used_slots[4:0].
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_POP  = 2'd1;
    localparam logic [1:0] ST_SRCH = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [WORD_BITS-1:0] slot_store [DEPTH];
    logic [WORD_BITS-1:0] rdata_reg;

    logic [1:0]           state_reg, state_next;
    logic [IDX_W-1:0]     wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0]     rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]     used_reg, used_next;

    logic [IDX_W-1:0]     scan_idx_reg, scan_idx_next;
    logic [CNT_W-1:0]     issued_reg, issued_next;
    logic                 cmp_valid_reg, cmp_valid_next;
    logic [CNT_W-1:0]     cmp_pos_reg, cmp_pos_next;
    logic [WORD_BITS-1:0] word_reg, word_next;

    logic                 res_ok_reg, res_ok_next;
    logic [WORD_BITS-1:0] res_rd_reg, res_rd_next;
    logic [CNT_W-1:0]     res_pos_reg, res_pos_next;

    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    logic [CMD_W-1:0]     in_cmd;
    logic [WORD_BITS-1:0] in_word;
    logic                 accept;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_raddr;
    logic                 issue;
    logic                 out_free;

    function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    assign in_cmd   = s_tdata[CMD_W-1:0];
    assign in_word  = s_tdata[CMD_W +: WORD_BITS];
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign mem_we   = accept && (in_cmd == CMD_PUSH) && (used_reg != FULL_CNT);
    assign issue    = (state_reg == ST_SRCH) && (issued_reg != used_reg);
    assign mem_raddr = (state_reg == ST_SRCH) ? scan_idx_reg : rd_idx_reg;
    assign out_free = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_store[wr_idx_reg] <= in_word;
        end
        rdata_reg <= slot_store[mem_raddr];
    end

    always_comb
    begin
        state_next     = state_reg;
        wr_idx_next    = wr_idx_reg;
        rd_idx_next    = rd_idx_reg;
        used_next      = used_reg;
        scan_idx_next  = scan_idx_reg;
        issued_next    = issued_reg;
        cmp_valid_next = 1'b0;
        cmp_pos_next   = cmp_pos_reg;
        word_next      = word_reg;
        res_ok_next    = res_ok_reg;
        res_rd_next    = res_rd_reg;
        res_pos_next   = res_pos_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_ok_next  = 1'b0;
                    res_rd_next  = '0;
                    res_pos_next = '0;
                    state_next   = ST_OUT;
                    if (in_cmd == CMD_PUSH)
                    begin
                        if (used_reg != FULL_CNT)
                        begin
                            wr_idx_next = advance(wr_idx_reg);
                            used_next   = used_reg + 1'b1;
                            res_ok_next = 1'b1;
                        end
                    end
                    else if (in_cmd == CMD_POP)
                    begin
                        // The memory read of the oldest slot is issued in this cycle.
                        if (used_reg != '0)
                        begin
                            rd_idx_next = advance(rd_idx_reg);
                            used_next   = used_reg - 1'b1;
                            res_ok_next = 1'b1;
                            state_next  = ST_POP;
                        end
                    end
                    else if (in_cmd == CMD_SEARCH)
                    begin
                        if (used_reg != '0)
                        begin
                            scan_idx_next = rd_idx_reg;
                            issued_next   = '0;
                            word_next     = in_word;
                            state_next    = ST_SRCH;
                        end
                    end
                end
            end

            ST_POP:
            begin
                res_rd_next = rdata_reg;
                state_next  = ST_OUT;
            end

            ST_SRCH:
            begin
                // Reads run one slot ahead of the comparator.
                if (issue)
                begin
                    scan_idx_next  = advance(scan_idx_reg);
                    issued_next    = issued_reg + 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_pos_next   = issued_reg + 1'b1;
                end
                if (cmp_valid_reg && (rdata_reg == word_reg))
                begin
                    res_ok_next    = 1'b1;
                    res_pos_next   = cmp_pos_reg;
                    cmp_valid_next = 1'b0;
                    state_next     = ST_OUT;
                end
                else if (cmp_valid_reg && (cmp_pos_reg == used_reg))
                begin
                    cmp_valid_next = 1'b0;
                    state_next     = ST_OUT;
                end
            end

            ST_OUT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {to_field5(32'(used_reg)),
                                    to_field5(32'(FULL_CNT - used_reg)),
                                    to_field5(32'(res_pos_reg)),
                                    MSG_W'(res_rd_reg),
                                    res_ok_reg};
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
            used_reg      <= '0;
            issued_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_idx_reg    <= wr_idx_next;
            rd_idx_reg    <= rd_idx_next;
            used_reg      <= used_next;
            issued_reg    <= issued_next;
            cmp_valid_reg <= cmp_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg <= scan_idx_next;
        cmp_pos_reg  <= cmp_pos_next;
        word_reg     <= word_next;
        res_ok_reg   <= res_ok_next;
        res_rd_reg   <= res_rd_next;
        res_pos_reg  <= res_pos_next;
        m_data_reg   <= m_data_next;
    end

endmodule
